// ===== rtl/hcs_pkg.sv =====
// Shared types and constants for the hashed character-set span counter.
// No dependencies; used by hcs_hash and hashed_charset_span_counter_top.
`default_nettype none

package hcs_pkg;

  // Multiplicative hash constant (about 2^32 divided by the golden ratio)
  localparam logic [31:0] KNUTH_MUL = 32'd2654435761;

  // Width of the member counter; it wraps at this width
  localparam int unsigned MEMBER_W = 10;

  // Reset value of the hash_bits register
  localparam logic [3:0] HASH_BITS_RESET = 4'd10;

  // Item kinds carried on tuser
  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_SCAN  = 2'd2
  } action_t;

endpackage

`default_nettype wire

// ===== rtl/hcs_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module hcs_ram #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/hcs_hash.sv =====
// Table geometry and home-slot hash: clamps hash_bits, derives slot mask and
// half-size, and computes the multiplicative home slot. Depends on hcs_pkg.
`default_nettype none

module hcs_hash #(
  parameter int unsigned SLOT_BITS = 10
) (
  input  wire logic [31:0]          char_value,
  input  wire logic [3:0]           hash_bits,
  output logic      [SLOT_BITS-1:0] home,
  output logic      [SLOT_BITS-1:0] mask,
  output logic      [SLOT_BITS-1:0] half
);

  logic [3:0]  eff_bits;
  logic [31:0] product;
  logic [5:0]  shift;

  // Clamp the slot-count exponent to what the table holds
  always_comb begin
    if (hash_bits < 4'd2) begin
      eff_bits = 4'd2;
    end else if (hash_bits > 4'(SLOT_BITS)) begin
      eff_bits = 4'(SLOT_BITS);
    end else begin
      eff_bits = hash_bits;
    end
  end

  // Low word of the product, top eff_bits bits give the home slot
  assign product = char_value * hcs_pkg::KNUTH_MUL;
  assign shift   = 6'd32 - {2'b00, eff_bits};
  assign home    = SLOT_BITS'(product >> shift);

  assign mask = ~({SLOT_BITS{1'b1}} << eff_bits);
  assign half = {{(SLOT_BITS-1){1'b0}}, 1'b1} << (eff_bits - 4'd1);

endmodule

`default_nettype wire

// ===== rtl/hashed_charset_span_counter_top.sv =====
// Top level of the hashed character-set span counter: control sequencer,
// probe logic and scan state. Depends on hcs_pkg, hcs_hash and hcs_ram.
//
// Holds a set of 32-bit characters in an open-addressed hash table (one RAM,
// one word per slot with an occupied bit) and counts how many leading
// characters of a scanned string are members. The accept cycle hashes and
// issues the RAM read of the home slot; the next cycle checks the registered
// word and retires if the answer is found there or no lookup is needed. Each
// collision issues a further probe read on the single RAM, up to 2^b probes,
// where b is hash_bits clamped to [2, log2 TABLE_SLOTS]. A clear item and the
// reset both sweep every slot, one per cycle, during which no item is taken
// (configuration writes still are). A scan that must emit while the result
// register is full and not being taken holds until it drains.
`default_nettype none

module hashed_charset_span_counter_top #(
  parameter int unsigned TABLE_SLOTS = 1024,
  parameter int unsigned COUNT_BITS  = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input items
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] char_value
  input  wire logic [1:0]  s_tuser,   // [1:0] action
  // Result items
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [31:0] m_tdata,   // [31:0] span_length
  // Configuration: hash_bits
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_data
);

  localparam int unsigned SLOT_BITS = $clog2(TABLE_SLOTS);
  localparam int unsigned RUN_W     = (COUNT_BITS < 32) ? COUNT_BITS : 32;
  localparam int unsigned CMP_W     = (SLOT_BITS > hcs_pkg::MEMBER_W) ?
                                      SLOT_BITS : hcs_pkg::MEMBER_W;
  localparam int unsigned WORD_W    = 33;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_WORK
  } state_t;

  state_t                        state;
  logic [3:0]                    hash_bits;
  logic [1:0]                    item_action;
  logic [31:0]                   item_char;
  logic [SLOT_BITS-1:0]          home;
  logic [SLOT_BITS-1:0]          probe_s;
  logic [SLOT_BITS-1:0]          tri_ofs;
  logic [SLOT_BITS-1:0]          cur_k;
  logic [SLOT_BITS-1:0]          sweep_cnt;
  logic [hcs_pkg::MEMBER_W-1:0]  member_count;
  logic [RUN_W-1:0]              run_count;
  logic                          span_stopped;

  logic [SLOT_BITS-1:0]          hash_home;
  logic [SLOT_BITS-1:0]          mask;
  logic [SLOT_BITS-1:0]          half;

  logic                          ram_we;
  logic [SLOT_BITS-1:0]          ram_waddr;
  logic [WORD_W-1:0]             ram_wdata;
  logic [SLOT_BITS-1:0]          ram_raddr;
  logic [WORD_W-1:0]             ram_rdata;

  logic                          rd_valid;
  logic [31:0]                   rd_char;
  logic                          char_nul;
  logic                          set_full;
  logic                          needs_probe;
  logic                          hit_empty;
  logic                          hit_match;
  logic                          last_probe;
  logic                          resolved;
  logic                          emit;
  logic                          stall;
  logic                          retire;
  logic [SLOT_BITS-1:0]          s_inc;
  logic [SLOT_BITS-1:0]          tri_inc;
  logic [SLOT_BITS-1:0]          k_inc;
  logic                          in_acc;

  hcs_hash #(
    .SLOT_BITS (SLOT_BITS)
  ) u_hash (
    .char_value (s_tdata),
    .hash_bits  (hash_bits),
    .home       (hash_home),
    .mask       (mask),
    .half       (half)
  );

  hcs_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = s_tvalid && s_tready;

  assign rd_valid = ram_rdata[WORD_W-1];
  assign rd_char  = ram_rdata[31:0];

  // Decide the fate of the held item from the slot word just read
  always_comb begin
    char_nul  = (item_char == 32'd0);
    set_full  = (CMP_W'(member_count) >= CMP_W'(half));
    hit_empty = !rd_valid;
    hit_match = rd_valid && (rd_char == item_char);
    last_probe = (probe_s == mask);
    needs_probe = 1'b0;
    emit        = 1'b0;
    unique case (item_action)
      hcs_pkg::ACT_ADD: begin
        needs_probe = !char_nul && !set_full;
      end
      hcs_pkg::ACT_SCAN: begin
        needs_probe = !span_stopped && !char_nul;
      end
      default: begin
        needs_probe = 1'b0;
      end
    endcase
    resolved = !needs_probe || hit_empty || hit_match || last_probe;
    if (item_action == hcs_pkg::ACT_SCAN && !span_stopped) begin
      emit = char_nul || (resolved && !hit_match);
    end
    stall  = emit && m_tvalid && !m_tready;
    retire = (state == ST_WORK) && resolved && !stall;
  end

  // Next probe on the triangular path
  assign s_inc   = probe_s + {{(SLOT_BITS-1){1'b0}}, 1'b1};
  assign tri_inc = tri_ofs + s_inc;
  assign k_inc   = (home + tri_inc) & mask;

  // Select read address and write port
  always_comb begin
    ram_raddr = cur_k;
    ram_we    = 1'b0;
    ram_waddr = cur_k;
    ram_wdata = {1'b1, item_char};
    unique case (state)
      ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_cnt;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        ram_raddr = hash_home;
      end
      ST_WORK: begin
        if (!resolved) begin
          ram_raddr = k_inc;
        end
        ram_we = retire && (item_action == hcs_pkg::ACT_ADD) && needs_probe &&
                 hit_empty;
      end
      default: begin
        ram_raddr = cur_k;
      end
    endcase
  end

  // Hold state, counters and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_SWEEP;
      sweep_cnt    <= '0;
      hash_bits    <= hcs_pkg::HASH_BITS_RESET;
      member_count <= '0;
      run_count    <= '0;
      span_stopped <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        hash_bits <= cfg_data;
      end
      // Drop the result once taken, unless a new one replaces it now
      if (m_tvalid && m_tready && !(retire && emit)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_SWEEP: begin
          sweep_cnt <= sweep_cnt + {{(SLOT_BITS-1){1'b0}}, 1'b1};
          if (sweep_cnt == SLOT_BITS'(TABLE_SLOTS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            item_action <= s_tuser;
            item_char   <= s_tdata;
            home        <= hash_home;
            cur_k       <= hash_home;
            probe_s     <= '0;
            tri_ofs     <= '0;
            if (s_tuser == hcs_pkg::ACT_CLEAR) begin
              member_count <= '0;
              sweep_cnt    <= '0;
              state        <= ST_SWEEP;
            end else begin
              state <= ST_WORK;
            end
          end
        end
        ST_WORK: begin
          if (!resolved) begin
            // Advance to the next probe
            probe_s <= s_inc;
            tri_ofs <= tri_inc;
            cur_k   <= k_inc;
          end else if (!stall) begin
            state <= ST_IDLE;
            if (item_action == hcs_pkg::ACT_ADD && needs_probe && hit_empty) begin
              member_count <= member_count + {{(hcs_pkg::MEMBER_W-1){1'b0}}, 1'b1};
            end
            if (item_action == hcs_pkg::ACT_SCAN) begin
              if (span_stopped) begin
                if (char_nul) begin
                  span_stopped <= 1'b0;
                  run_count    <= '0;
                end
              end else if (emit) begin
                m_tvalid     <= 1'b1;
                m_tdata      <= 32'(run_count);
                run_count    <= '0;
                span_stopped <= !char_nul;
              end else if (run_count != {RUN_W{1'b1}}) begin
                run_count <= run_count + {{(RUN_W-1){1'b0}}, 1'b1};
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A stopped string has nothing counted
  a_stopped_run_zero: assert property (@(posedge clk) disable iff (rst)
    span_stopped |-> (run_count == '0))
    else $error("run count non-zero while span stopped");

  // Probe index stays inside the active table
  a_probe_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WORK) |-> ((probe_s & ~mask) == '0))
    else $error("probe index beyond active slot count");

  // A result is only raised when retiring a scan
  a_emit_on_scan: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid ##1 m_tvalid) |->
      ($past(state) == ST_WORK && $past(item_action) == hcs_pkg::ACT_SCAN))
    else $error("result raised outside a retiring scan");

  // Table writes happen only in the sweep or when an add retires
  a_write_source: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_SWEEP ||
                (retire && item_action == hcs_pkg::ACT_ADD)))
    else $error("unexpected slot write");

  // No item is taken while the table is being swept
  a_no_accept_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP) |-> !s_tready)
    else $error("item accepted during sweep");

endmodule

`default_nettype wire

// ===== tb/hashed_charset_span_counter_top_tb.sv =====
// Testbench for hashed_charset_span_counter_top: directed table, then random
// phases over several hash_bits settings, checked against an in-bench predictor.
// Depends on hcs_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module hashed_charset_span_counter_top_tb;

  localparam int unsigned TABLE_SLOTS = 1024;
  localparam int unsigned COUNT_BITS  = 32;
  localparam int unsigned MAX_BITS    = 10;      // log2 of TABLE_SLOTS
  localparam int unsigned SETTLE_CYCLES = TABLE_SLOTS + 80;
  localparam int unsigned LONG_HOLD   = 1500;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned NUM_PHASES  = 9;
  localparam int unsigned PHASE_ITEMS = 125;

  // Action code the block drops without a result
  localparam logic [1:0] ACT_IGNORE = 2'd3;

  // Directed rows: expected result typed in, or taken from the predictor
  localparam logic FROM_MODEL = 1'b0;
  localparam logic TYPED      = 1'b1;
  localparam logic SILENT     = 1'b0;
  localparam logic EMITS      = 1'b1;

  typedef struct packed {
    logic [1:0]  act;
    logic [31:0] ch;
    logic        typed;
    logic        emits;
    logic [31:0] span;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 26;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // empty string and a miss on the empty set straight after reset
    '{hcs_pkg::ACT_SCAN,  32'h0000_0000, TYPED,      EMITS,  32'd0},
    '{hcs_pkg::ACT_SCAN,  32'hFFFF_FFFF, TYPED,      EMITS,  32'd0},
    // stopped: ignore characters until a nul, which emits nothing
    '{hcs_pkg::ACT_SCAN,  32'h0000_0005, TYPED,      SILENT, 32'd0},
    '{hcs_pkg::ACT_SCAN,  32'h0000_0000, TYPED,      SILENT, 32'd0},
    // adds: nul, extremes, a duplicate
    '{hcs_pkg::ACT_ADD,   32'h0000_0000, TYPED,      SILENT, 32'd0},
    '{hcs_pkg::ACT_ADD,   32'hFFFF_FFFF, TYPED,      SILENT, 32'd0},
    '{hcs_pkg::ACT_ADD,   32'h0000_0001, TYPED,      SILENT, 32'd0},
    '{hcs_pkg::ACT_ADD,   32'h0000_0001, TYPED,      SILENT, 32'd0},
    '{hcs_pkg::ACT_ADD,   32'h8000_0000, TYPED,      SILENT, 32'd0},
    '{hcs_pkg::ACT_ADD,   32'h1234_5678, TYPED,      SILENT, 32'd0},
    // full string of members, ended by nul
    '{hcs_pkg::ACT_SCAN,  32'h0000_0001, FROM_MODEL, SILENT, 32'd0},
    '{hcs_pkg::ACT_SCAN,  32'hFFFF_FFFF, FROM_MODEL, SILENT, 32'd0},
    '{hcs_pkg::ACT_SCAN,  32'h8000_0000, FROM_MODEL, SILENT, 32'd0},
    '{hcs_pkg::ACT_SCAN,  32'h1234_5678, FROM_MODEL, SILENT, 32'd0},
    '{hcs_pkg::ACT_SCAN,  32'h0000_0000, FROM_MODEL, SILENT, 32'd0},
    // unused action code
    '{ACT_IGNORE,         32'hFFFF_FFFF, TYPED,      SILENT, 32'd0},
    // member then non-member, then trailing characters ignored
    '{hcs_pkg::ACT_SCAN,  32'h0000_0001, FROM_MODEL, SILENT, 32'd0},
    '{hcs_pkg::ACT_SCAN,  32'hDEAD_BEEF, FROM_MODEL, SILENT, 32'd0},
    '{hcs_pkg::ACT_SCAN,  32'h0000_0001, TYPED,      SILENT, 32'd0},
    '{hcs_pkg::ACT_SCAN,  32'h0000_0000, TYPED,      SILENT, 32'd0},
    // clear in mid-string keeps the running count
    '{hcs_pkg::ACT_SCAN,  32'h8000_0000, FROM_MODEL, SILENT, 32'd0},
    '{hcs_pkg::ACT_CLEAR, 32'hFFFF_FFFF, TYPED,      SILENT, 32'd0},
    '{hcs_pkg::ACT_SCAN,  32'h0000_0000, FROM_MODEL, SILENT, 32'd0},
    // set now empty
    '{hcs_pkg::ACT_SCAN,  32'h0000_0001, TYPED,      EMITS,  32'd0},
    '{hcs_pkg::ACT_SCAN,  32'h0000_0000, TYPED,      SILENT, 32'd0},
    '{hcs_pkg::ACT_SCAN,  32'h0000_0000, TYPED,      EMITS,  32'd0}
  };

  localparam logic [3:0] PHASE_BITS [NUM_PHASES] =
    '{4'd2, 4'd0, 4'd15, 4'd5, 4'd10, 4'd1, 4'd12, 4'd3, 4'd7};
  localparam int unsigned SQUEEZE_PHASE = 3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_data = '0;

  // Predictor state
  logic [31:0] set_char [TABLE_SLOTS];
  logic        set_used [TABLE_SLOTS];
  logic [9:0]  set_size;
  logic [31:0] run_len;
  logic        run_halted;
  logic [3:0]  hash_bits_reg;

  logic [31:0] span_q [$];        // spans still to come out
  logic [31:0] charset_pool [$];  // characters added since the last clear
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_reqs = 0;
  int unsigned holds_done = 0;
  bit          gapless = 1'b0;

  hashed_charset_span_counter_top #(
    .TABLE_SLOTS(TABLE_SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Clamp hash_bits to the range the table supports
  function automatic int eff_hash_bits();
    int b;
    b = int'(hash_bits_reg);
    if (b > int'(MAX_BITS)) b = MAX_BITS;
    if (b < 2) b = 2;
    return b;
  endfunction

  // Walk the triangular probe path: slot of ch, or first empty slot on it
  task automatic charset_probe(input logic [31:0] ch, output bit hit, output int slot);
    int bits, n, h, k;
    logic [31:0] prod;
    bits = eff_hash_bits();
    n = 1 << bits;
    prod = ch * hcs_pkg::KNUTH_MUL;
    h = int'(prod >> (32 - bits));
    hit = 1'b0;
    slot = TABLE_SLOTS;
    for (int s = 0; s < n; s++) begin
      k = (h + s * (s + 1) / 2) & (n - 1);
      if (!set_used[k]) begin
        slot = k;
        return;
      end
      if (set_char[k] == ch) begin
        hit = 1'b1;
        slot = k;
        return;
      end
    end
  endtask

  // Advance the predictor by one item; say whether it yields a span
  task automatic span_step(input logic [1:0] act, input logic [31:0] ch,
                           output bit emits, output logic [31:0] span);
    bit hit;
    int slot;
    emits = 1'b0;
    span = '0;
    case (act)
      hcs_pkg::ACT_CLEAR: begin
        for (int i = 0; i < TABLE_SLOTS; i++) set_used[i] = 1'b0;
        set_size = '0;
      end
      hcs_pkg::ACT_ADD: begin
        if (ch != 0 && int'(set_size) < (1 << eff_hash_bits()) / 2) begin
          charset_probe(ch, hit, slot);
          if (!hit && slot < TABLE_SLOTS) begin
            set_char[slot] = ch;
            set_used[slot] = 1'b1;
            set_size = set_size + 10'd1;
          end
        end
      end
      hcs_pkg::ACT_SCAN: begin
        if (run_halted) begin
          if (ch == 0) begin
            run_halted = 1'b0;
            run_len = '0;
          end
        end else begin
          hit = 1'b0;
          if (ch != 0) charset_probe(ch, hit, slot);
          if (hit) begin
            if (run_len != 32'hFFFF_FFFF) run_len = run_len + 32'd1;
          end else begin
            if (ch != 0) run_halted = 1'b1;
            emits = 1'b1;
            span = run_len;
            run_len = '0;
          end
        end
      end
      default: ;
    endcase
  endtask

  // Mostly short gaps, a few long ones, none in gapless stretches
  function automatic int pick_gap();
    int r;
    if (gapless) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Offer one item, wait for it to be taken, then predict its result
  task automatic offer_item(input logic [1:0] act, input logic [31:0] ch,
                            input logic typed = 1'b0, input logic typed_emits = 1'b0,
                            input logic [31:0] typed_span = '0);
    int gap;
    bit emits;
    logic [31:0] span;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= ch;
    do @(posedge clk); while (!s_tready);
    span_step(act, ch, emits, span);
    if (typed) begin
      emits = typed_emits;
      span = typed_span;
    end
    if (emits) span_q.push_back(span);
    if (act == hcs_pkg::ACT_CLEAR) charset_pool.delete();
    if (act == hcs_pkg::ACT_ADD && ch != 0) charset_pool.push_back(ch);
  endtask

  // Write hash_bits once the block has gone quiet
  task automatic write_hash_bits(input logic [3:0] value);
    s_tvalid <= 1'b0;
    while (span_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    hash_bits_reg = value;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_member();
    if (charset_pool.size() == 0) return $urandom;
    return charset_pool[$urandom_range(0, charset_pool.size() - 1)];
  endfunction

  // One string: mostly members, ended by nul or by a miss plus ignored tail
  task automatic send_string(output int count);
    int len, tail;
    len = $urandom_range(0, 10);
    count = 0;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 85) offer_item(hcs_pkg::ACT_SCAN, pick_member());
      else offer_item(hcs_pkg::ACT_SCAN, $urandom);
      count++;
    end
    if ($urandom_range(0, 99) >= 65) begin
      offer_item(hcs_pkg::ACT_SCAN, $urandom | 32'd1);
      tail = $urandom_range(0, 3);
      for (int i = 0; i < tail; i++) offer_item(hcs_pkg::ACT_SCAN, pick_member());
      count += tail + 1;
      if ($urandom_range(0, 9) == 0) return;   // leave the string unterminated
    end
    offer_item(hcs_pkg::ACT_SCAN, 32'd0);
    count++;
  endtask

  // Random phase: maybe clear, fill the set, then strings with some noise
  task automatic run_phase(input int budget, input bit squeeze);
    int used, adds, cap, r, n;
    used = 0;
    if ($urandom_range(0, 99) < 70) begin
      offer_item(hcs_pkg::ACT_CLEAR, $urandom);
      used++;
    end
    cap = (1 << eff_hash_bits()) / 2 + 2;
    if (cap > 40) cap = 40;
    adds = $urandom_range(1, cap);
    for (int i = 0; i < adds; i++) begin
      if (charset_pool.size() != 0 && $urandom_range(0, 9) == 0)
        offer_item(hcs_pkg::ACT_ADD, pick_member());
      else
        offer_item(hcs_pkg::ACT_ADD, $urandom);
      used++;
    end
    // Hold off the receiver and offer 48 scans so that the block backs up
    if (squeeze) begin
      hold_reqs++;
      gapless = 1'b1;
      for (int i = 0; i < 48; i++) begin
        if (i % 3 == 2) offer_item(hcs_pkg::ACT_SCAN, 32'd0);
        else offer_item(hcs_pkg::ACT_SCAN, pick_member());
        used++;
      end
    end
    while (used < budget) begin
      gapless = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 78) begin
        send_string(n);
        used += n;
      end else if (r < 85) begin
        offer_item(hcs_pkg::ACT_ADD,
                   ($urandom_range(0, 3) == 0) ? pick_member() : $urandom);
        used++;
      end else if (r < 90) begin
        offer_item(ACT_IGNORE, $urandom);
        used++;
      end else if (r < 93) begin
        offer_item(hcs_pkg::ACT_CLEAR, $urandom);
        used++;
      end else begin
        offer_item(hcs_pkg::ACT_SCAN, ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom);
        used++;
      end
    end
    gapless = 1'b0;
  endtask

  // Stimulus and end of run
  initial begin : stimulus
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      set_char[i] = '0;
      set_used[i] = 1'b0;
    end
    set_size = '0;
    run_len = '0;
    run_halted = 1'b0;
    hash_bits_reg = hcs_pkg::HASH_BITS_RESET;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i])
      offer_item(DIRECTED[i].act, DIRECTED[i].ch, DIRECTED[i].typed,
                 DIRECTED[i].emits, DIRECTED[i].span);

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_hash_bits(PHASE_BITS[p]);
      run_phase(PHASE_ITEMS, p == SQUEEZE_PHASE);
    end

    // Drain, then let any silent work finish
    s_tvalid <= 1'b0;
    while (span_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && span_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Receiver: random ready runs and stalls, one long hold on request
  initial begin : result_sink
    int run, stall, r;
    @(posedge clk);
    forever begin
      if (holds_done != hold_reqs) begin
        holds_done = hold_reqs;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        run = (r < 15) ? $urandom_range(100, 300) : $urandom_range(1, 24);
        m_tready <= 1'b1;
        repeat (run) @(posedge clk);
        r = $urandom_range(0, 99);
        if (r < 40) stall = 0;
        else if (r < 85) stall = $urandom_range(1, 3);
        else if (r < 97) stall = $urandom_range(4, 15);
        else stall = $urandom_range(20, 60);
        if (stall > 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  // Compare each result with the oldest expected span
  always @(posedge clk) begin : result_check
    logic [31:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (span_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result: span_length=%0d", m_tdata);
      end else begin
        want = span_q.pop_front();
        if (m_tdata !== want) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("span_length mismatch: expected %0d, got %0d", want, m_tdata);
        end
      end
    end
  end

  // Stop a run that hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule
